// File: src/sh2_pkg.sv
// Shared types, fixed-point constants and rounding helper for the SH degree-2 evaluator.
`default_nettype none
package sh2_pkg;

  localparam int unsigned NUM_TERMS = 9;
  localparam int unsigned BASIS_W   = 36;   // widest basis value in Q.30
  localparam int unsigned ACC_W     = 56;   // exact sum of nine 52-bit products
  localparam int unsigned PROD_W    = 52;   // 16 x 36 signed product

  // Normalization constants, Q.30, round to nearest
  localparam logic signed [31:0] KC0     =  32'sd302896976;
  localparam logic signed [31:0] KC1     =  32'sd524632952;
  localparam logic signed [31:0] NEG_KC1 = -32'sd524632952;
  localparam logic signed [31:0] KC2     =  32'sd1015947344;
  localparam logic signed [31:0] KC3     =  32'sd338649115;
  localparam logic signed [31:0] NEG_KC5 = -32'sd1173114945;
  localparam logic signed [31:0] KC6     =  32'sd586557472;

  localparam logic signed [63:0] SAT_MAX =  64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef logic signed [15:0]        coeff_t;
  typedef logic signed [BASIS_W-1:0] basis_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // One item in flight through the cell row
  typedef struct packed {
    logic                        valid;
    basis_t [NUM_TERMS-1:0]      basis;
    coeff_t [NUM_TERMS-1:0]      coeff;
    acc_t                        acc;
  } lane_t;

  // Arithmetic right shift, round to nearest, ties away from zero.
  // (v + half - neg) >>> s gives the ceiling form for negative values.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] half;
    logic signed [63:0] neg;
    half = 64'sd1 <<< (s - 1);
    neg  = v[63] ? 64'sd1 : 64'sd0;
    return (v + half - neg) >>> s;
  endfunction

endpackage
`default_nettype wire

// File: src/sh2_basis.sv
// Four-stage basis generator: direction products, rounding, second products, final basis.
`default_nettype none
module sh2_basis (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       en,
  input  wire                                       in_valid,
  input  wire  logic signed [15:0]                  dir_x,
  input  wire  logic signed [15:0]                  dir_y,
  input  wire  logic signed [15:0]                  dir_z,
  input  wire  sh2_pkg::coeff_t [sh2_pkg::NUM_TERMS-1:0] coeff,
  output sh2_pkg::lane_t                            lane_o
);
  import sh2_pkg::*;

  // stage A: first products
  logic                        va_r;
  logic signed [47:0]          py_r, pz_r, px_r, pzs_r;
  logic signed [31:0]          xx_r, yy_r, xy_r, zz_r;
  logic signed [15:0]          xa_r, ya_r;
  coeff_t [NUM_TERMS-1:0]      ca_r;
  // stage B: rounded band-one terms and shared factors
  logic                        vb_r;
  logic signed [33:0]          b1_r, b2_r, b3_r, zs_r;
  logic signed [32:0]          cc_r, ss_r;
  logic signed [31:0]          sq_r;
  logic signed [15:0]          xb_r, yb_r;
  coeff_t [NUM_TERMS-1:0]      cb_r;
  // stage C: band-two products
  logic                        vc_r;
  logic signed [63:0]          m4_r, m6_r, m8_r;
  logic signed [51:0]          m5_r, m7_r;
  logic signed [33:0]          b1c_r, b2c_r, b3c_r;
  coeff_t [NUM_TERMS-1:0]      cc_coef_r;
  // stage D: full basis
  logic                        vd_r;
  basis_t [NUM_TERMS-1:0]      bd_r;
  coeff_t [NUM_TERMS-1:0]      cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      py_r  <= 48'(NEG_KC1) * 48'(dir_y);
      pz_r  <= 48'(KC1) * 48'(dir_z);
      px_r  <= 48'(NEG_KC1) * 48'(dir_x);
      pzs_r <= 48'(NEG_KC5) * 48'(dir_z);
      xx_r  <= 32'(dir_x) * 32'(dir_x);
      yy_r  <= 32'(dir_y) * 32'(dir_y);
      xy_r  <= 32'(dir_x) * 32'(dir_y);
      zz_r  <= 32'(dir_z) * 32'(dir_z);
      xa_r  <= dir_x;
      ya_r  <= dir_y;
      ca_r  <= coeff;

      b1_r  <= 34'(rnd_shift(64'(py_r), 14));
      b2_r  <= 34'(rnd_shift(64'(pz_r), 14));
      b3_r  <= 34'(rnd_shift(64'(px_r), 14));
      zs_r  <= 34'(rnd_shift(64'(pzs_r), 14));
      cc_r  <= 33'(xx_r) - 33'(yy_r);
      ss_r  <= 33'(xy_r) <<< 1;
      sq_r  <= zz_r;
      xb_r  <= xa_r;
      yb_r  <= ya_r;
      cb_r  <= ca_r;

      m4_r      <= 64'(KC6) * 64'(ss_r);
      m6_r      <= 64'(KC2) * 64'(sq_r);
      m8_r      <= 64'(KC6) * 64'(cc_r);
      m5_r      <= 52'(zs_r) * 52'(yb_r);
      m7_r      <= 52'(zs_r) * 52'(xb_r);
      b1c_r     <= b1_r;
      b2c_r     <= b2_r;
      b3c_r     <= b3_r;
      cc_coef_r <= cb_r;

      bd_r[0] <= BASIS_W'(KC0);
      bd_r[1] <= BASIS_W'(b1c_r);
      bd_r[2] <= BASIS_W'(b2c_r);
      bd_r[3] <= BASIS_W'(b3c_r);
      bd_r[4] <= BASIS_W'(rnd_shift(m4_r, 28));
      bd_r[5] <= BASIS_W'(rnd_shift(64'(m5_r), 14));
      bd_r[6] <= BASIS_W'(rnd_shift(m6_r, 28) - 64'(KC3));
      bd_r[7] <= BASIS_W'(rnd_shift(64'(m7_r), 14));
      bd_r[8] <= BASIS_W'(rnd_shift(m8_r, 28));
      cd_r    <= cc_coef_r;
    end
  end

  assign lane_o.valid = vd_r;
  assign lane_o.basis = bd_r;
  assign lane_o.coeff = cd_r;
  assign lane_o.acc   = '0;

endmodule
`default_nettype wire

// File: src/sh2_mac_cell.sv
// One multiply-accumulate cell of the row: adds coeff[IDX] * basis[IDX] to the running sum.
`default_nettype none
module sh2_mac_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire sh2_pkg::lane_t  lane_i,
  output sh2_pkg::lane_t       lane_o
);
  import sh2_pkg::*;

  logic                        valid_r;
  basis_t [NUM_TERMS-1:0]      basis_r;
  coeff_t [NUM_TERMS-1:0]      coeff_r;
  acc_t                        acc_r;
  logic signed [PROD_W-1:0]    prod;
  acc_t                        acc_nxt;

  always_comb begin
    prod    = PROD_W'($signed(lane_i.coeff[IDX])) * PROD_W'($signed(lane_i.basis[IDX]));
    acc_nxt = $signed(lane_i.acc) + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= lane_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      basis_r <= lane_i.basis;
      coeff_r <= lane_i.coeff;
      acc_r   <= acc_nxt;
    end
  end

  assign lane_o.valid = valid_r;
  assign lane_o.basis = basis_r;
  assign lane_o.coeff = coeff_r;
  assign lane_o.acc   = acc_r;

endmodule
`default_nettype wire

// File: src/sh_degree2_color_eval_core.sv
// Top level: degree-2 spherical-harmonic color evaluation, basis pipeline plus MAC cell row.
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid, in_stall, in_dir_*, in_coeff_0..8 | into core
//  out     | out_valid, out_stall, out_shade_sum         | out of core
//
// One beat per clock in and out when out_stall is low; the path runs through
// 4 basis stages, 9 MAC cells and 1 output register.
// The whole pipe advances together: it moves whenever the output register is
// empty or being taken, so under out_stall it keeps moving until a result lands there.
// in_stall is high only while a finished result waits on out_stall.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`default_nettype none
module sh_degree2_color_eval_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  logic signed [15:0] in_dir_x,
  input  wire  logic signed [15:0] in_dir_y,
  input  wire  logic signed [15:0] in_dir_z,
  input  wire  logic signed [15:0] in_coeff_0,
  input  wire  logic signed [15:0] in_coeff_1,
  input  wire  logic signed [15:0] in_coeff_2,
  input  wire  logic signed [15:0] in_coeff_3,
  input  wire  logic signed [15:0] in_coeff_4,
  input  wire  logic signed [15:0] in_coeff_5,
  input  wire  logic signed [15:0] in_coeff_6,
  input  wire  logic signed [15:0] in_coeff_7,
  input  wire  logic signed [15:0] in_coeff_8,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [31:0]  out_shade_sum
);
  import sh2_pkg::*;

  logic                    adv;
  coeff_t [NUM_TERMS-1:0]  coeff;
  lane_t                   chain [NUM_TERMS+1];
  logic signed [63:0]      rnd;
  logic signed [31:0]      sat_nxt;
  logic                    out_valid_r;
  logic signed [31:0]      out_shade_sum_r;

  // global advance: output slot free or being drained this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign coeff[0] = in_coeff_0;
  assign coeff[1] = in_coeff_1;
  assign coeff[2] = in_coeff_2;
  assign coeff[3] = in_coeff_3;
  assign coeff[4] = in_coeff_4;
  assign coeff[5] = in_coeff_5;
  assign coeff[6] = in_coeff_6;
  assign coeff[7] = in_coeff_7;
  assign coeff[8] = in_coeff_8;

  sh2_basis u_basis (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .coeff    (coeff),
    .lane_o   (chain[0])
  );

  // one cell per basis term; each adds its own product and hands the sum on
  for (genvar g = 0; g < NUM_TERMS; g++) begin : g_cell
    sh2_mac_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  // Q.42 sum back to Q.16, then clip to the 32-bit range
  always_comb begin
    rnd = rnd_shift(64'($signed(chain[NUM_TERMS].acc)), 26);
    priority if (rnd > SAT_MAX) begin
      sat_nxt = 32'(SAT_MAX);
    end else if (rnd < SAT_MIN) begin
      sat_nxt = 32'(SAT_MIN);
    end else begin
      sat_nxt = 32'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[NUM_TERMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_shade_sum_r <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_shade_sum = out_shade_sum_r;

endmodule
`default_nettype wire

// File: src/sh2_checker.sv
// Port-level checker for the SH degree-2 evaluator and its bind to the top level.
`default_nettype none
module sh2_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire  logic [31:0] out_shade_sum
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shade_sum))
    else $error("result beat changed while stalled");

  // input backpressure only when a finished result is blocked
  a_stall_src: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow blocked output");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out_valid set right after reset");

  // a blocked result keeps the input side blocked until taken
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_stall || !$past(out_stall) || !out_stall)
    else $error("input released while output still blocked");

endmodule

bind sh_degree2_color_eval_core sh2_checker u_sh2_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_shade_sum (out_shade_sum)
);
`default_nettype wire
